// File: hw/rtl/u2a_pkg.sv
// Shared types, constants and helpers for the unsigned-to-ASCII digit converter.
`default_nettype none

package u2a_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned NumCells   = 10;
  localparam int unsigned CharWidth  = 7;
  localparam int unsigned BitCntWidth = $clog2(ValueWidth);
  localparam int unsigned DigCntWidth = $clog2(NumCells + 1);

  localparam logic [CharWidth-1:0] AsciiZero = 7'h30;
  localparam logic [CharWidth-1:0] AsciiA    = 7'h41;
  localparam logic [DigitWidth-1:0] DecRadix = 4'd10;

  // Command codes
  typedef enum logic {
    CMD_DEC = 1'b0,
    CMD_HEX = 1'b1
  } cmd_t;

  // Operation applied to every cell of the chain in the same cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_SHIFT_BIT,
    CELL_SHIFT_DIGIT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     hex;
  } cell_ctrl_t;

  typedef struct packed {
    logic                  command;
    logic [ValueWidth-1:0] value;
  } request_t;

  typedef struct packed {
    logic [CharWidth-1:0] character;
    logic                 last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  // Add-3 correction of double dabble; hex mode passes the digit through.
  function automatic logic [DigitWidth-1:0] dabble_fix(input logic [DigitWidth-1:0] d,
                                                       input logic hex);
    if (!hex && (d >= 4'd5)) begin
      dabble_fix = d + 4'd3;
    end else begin
      dabble_fix = d;
    end
  endfunction

  function automatic logic [CharWidth-1:0] digit_to_ascii(input logic [DigitWidth-1:0] d);
    if (d < DecRadix) begin
      digit_to_ascii = AsciiZero + {3'b000, d};
    end else begin
      digit_to_ascii = AsciiA + {3'b000, d - DecRadix};
    end
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/u2a_digit_cell.sv
// One digit cell of the conversion chain: double-dabble step or digit shift.
`default_nettype none

module u2a_digit_cell (
  input  wire logic                            clk,
  input  wire u2a_pkg::cell_ctrl_t             ctrl,
  input  wire logic [u2a_pkg::DigitWidth-1:0]  nb_digit,
  output logic [u2a_pkg::DigitWidth-1:0]       digit
);

  logic [u2a_pkg::DigitWidth-1:0] own_fix;
  logic [u2a_pkg::DigitWidth-1:0] nb_fix;
  logic [u2a_pkg::DigitWidth-1:0] digit_next;

  // The carry into this cell is the top bit of the lower neighbor after its correction.
  assign own_fix = u2a_pkg::dabble_fix(digit, ctrl.hex);
  assign nb_fix  = u2a_pkg::dabble_fix(nb_digit, ctrl.hex);

  always_comb begin
    case (ctrl.op)
      u2a_pkg::CELL_CLEAR:       digit_next = '0;
      u2a_pkg::CELL_SHIFT_BIT:   digit_next = {own_fix[u2a_pkg::DigitWidth-2:0],
                                               nb_fix[u2a_pkg::DigitWidth-1]};
      u2a_pkg::CELL_SHIFT_DIGIT: digit_next = nb_digit;
      default:                   digit_next = digit;
    endcase
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

`default_nettype wire

// File: hw/rtl/unsigned_to_ascii_digits.sv
// Top level: converts a 32-bit unsigned value to ASCII decimal or hex digits.
`default_nettype none

// A transaction is taken when start is high and busy is low. The value is then
// shifted one bit per cycle into a chain of ten 4-bit digit cells
// (double dabble with add-3 correction in decimal, plain nibble shift in hex).
// The chain then moves up one digit per cycle; leading zeros are dropped and
// every significant digit appears on result for exactly one cycle with
// result_valid high, most significant first, last set on the final digit.
// A transaction runs through the accept, the bit shift over all 32 value bits and
// the sweep of the ten digit cells to the last digit. busy falls in the cycle the
// last digit is shown, so the next start may follow at once. The receiver cannot
// stall: each result must be taken in its cycle.
module unsigned_to_ascii_digits (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire u2a_pkg::request_t request,
  output logic                   busy,
  output logic                   result_valid,
  output u2a_pkg::result_t       result
);

  u2a_pkg::state_t                   state, state_next;
  logic [u2a_pkg::ValueWidth-1:0]    shreg, shreg_next;
  logic [u2a_pkg::BitCntWidth-1:0]   bit_cnt, bit_cnt_next;
  logic [u2a_pkg::DigCntWidth-1:0]   remaining, remaining_next;
  logic                              started, started_next;
  logic                              hex, hex_next;
  logic                              result_valid_next;
  u2a_pkg::result_t                  result_next;
  u2a_pkg::cell_ctrl_t               cell_ctrl;

  logic [u2a_pkg::DigitWidth-1:0]    digits [u2a_pkg::NumCells];
  logic [u2a_pkg::DigitWidth-1:0]    top_digit;

  assign top_digit = digits[u2a_pkg::NumCells-1];
  assign busy      = (state != u2a_pkg::ST_IDLE);

  // Cell chain: cell 0 sees the value's top bit posing as a neighbor digit, so
  // its carry in after correction is exactly that bit; once the value is
  // shifted out it feeds zeros during the digit sweep.
  for (genvar i = 0; i < u2a_pkg::NumCells; i++) begin : g_cell
    logic [u2a_pkg::DigitWidth-1:0] nb;
    if (i == 0) begin : g_first
      assign nb = {shreg[u2a_pkg::ValueWidth-1], {(u2a_pkg::DigitWidth-1){1'b0}}};
    end else begin : g_rest
      assign nb = digits[i-1];
    end
    u2a_digit_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .nb_digit (nb),
      .digit    (digits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= u2a_pkg::ST_IDLE;
      result_valid <= 1'b0;
      bit_cnt      <= '0;
      remaining    <= '0;
      started      <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
      bit_cnt      <= bit_cnt_next;
      remaining    <= remaining_next;
      started      <= started_next;
    end
  end

  always_ff @(posedge clk) begin
    shreg  <= shreg_next;
    hex    <= hex_next;
    result <= result_next;
  end

  always_comb begin
    state_next        = state;
    shreg_next        = shreg;
    bit_cnt_next      = bit_cnt;
    remaining_next    = remaining;
    started_next      = started;
    hex_next          = hex;
    result_valid_next = 1'b0;
    result_next       = result;
    cell_ctrl.op      = u2a_pkg::CELL_HOLD;
    cell_ctrl.hex     = hex;

    unique case (state)
      u2a_pkg::ST_IDLE: begin
        if (start) begin
          // Take the transaction and clear the chain.
          shreg_next   = request.value;
          hex_next     = (request.command == u2a_pkg::CMD_HEX);
          bit_cnt_next = '0;
          cell_ctrl.op = u2a_pkg::CELL_CLEAR;
          state_next   = u2a_pkg::ST_CONVERT;
        end
      end

      u2a_pkg::ST_CONVERT: begin
        // Advance one value bit into the chain.
        cell_ctrl.op = u2a_pkg::CELL_SHIFT_BIT;
        shreg_next   = {shreg[u2a_pkg::ValueWidth-2:0], 1'b0};
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == u2a_pkg::BitCntWidth'(u2a_pkg::ValueWidth - 1)) begin
          remaining_next = u2a_pkg::DigCntWidth'(u2a_pkg::NumCells);
          started_next   = 1'b0;
          state_next     = u2a_pkg::ST_EMIT;
        end
      end

      u2a_pkg::ST_EMIT: begin
        // Sweep digits upward; drop leading zeros but always keep the last digit.
        cell_ctrl.op   = u2a_pkg::CELL_SHIFT_DIGIT;
        remaining_next = remaining - 1'b1;
        if (started || (top_digit != '0) || (remaining == 1)) begin
          started_next          = 1'b1;
          result_valid_next     = 1'b1;
          result_next.character = u2a_pkg::digit_to_ascii(top_digit);
          result_next.last      = (remaining == 1);
        end
        if (remaining == 1) begin
          state_next = u2a_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = u2a_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: verif/unsigned_to_ascii_digits_tb.sv
// Self-checking testbench for the unsigned-to-ASCII digit converter.
`timescale 1ns / 1ps

// Predicts the digit stream of each accepted transaction and checks every
// result strobe against the oldest predicted digit.
class digit_scoreboard;
  u2a_pkg::result_t expected_digits[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  // Split the value into digits, least significant first, then queue them
  // most significant first with the final one marked.
  function void note_request(u2a_pkg::request_t req);
    logic [3:0]       rev[10];
    logic [31:0]      rest;
    logic [31:0]      radix;
    int               n;
    u2a_pkg::result_t digit;
    rest  = req.value;
    radix = (req.command == u2a_pkg::CMD_HEX) ? 32'd16 : 32'd10;
    n     = 0;
    do begin
      rev[n] = 4'(rest % radix);
      rest   = rest / radix;
      n++;
    end while (rest != 0);
    for (int k = n - 1; k >= 0; k--) begin
      if (rev[k] < 4'd10) begin
        digit.character = u2a_pkg::AsciiZero + 7'(rev[k]);
      end else begin
        digit.character = u2a_pkg::AsciiA + 7'(rev[k]) - 7'd10;
      end
      digit.last = (k == 0);
      expected_digits.push_back(digit);
    end
  endfunction

  function void check_digit(u2a_pkg::result_t got);
    u2a_pkg::result_t want;
    if (expected_digits.size() == 0) begin
      $error("unexpected digit: character %0h last %0b", got.character, got.last);
      errors++;
    end else begin
      want = expected_digits.pop_front();
      if (got.character !== want.character) begin
        $error("character mismatch: expected %0h, actual %0h", want.character, got.character);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    end
  endfunction

  function int pending();
    return expected_digits.size();
  endfunction
endclass

module unsigned_to_ascii_digits_tb;

  localparam int IdleLimit   = 2000;  // cycles with no transfer before giving up
  localparam int DrainCycles = 50;    // settle time after the last digit
  localparam int PhaseItems  = 82;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  u2a_pkg::request_t request = '0;
  logic              busy;
  logic              result_valid;
  u2a_pkg::result_t  result;

  digit_scoreboard board;
  int idle_cycles = 0;

  unsigned_to_ascii_digits uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Monitor: sample at the rising edge, before any update of this edge lands.
  // A digit strobe is taken in its one cycle; a request when start meets !busy.
  // Digits are checked before the new request is noted, though the queue order
  // makes either order safe. The watchdog counts edges that move nothing.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) begin
        board.check_digit(result);
      end
      if (start && !busy) begin
        board.note_request(request);
      end
      if (result_valid || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("unsigned_to_ascii_digits test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one transaction. With probability idle_pct, first drop start for a
  // random gap long enough to land anywhere in the conversion, and scramble the
  // request bus meanwhile. Then hold the request until taken.
  task automatic send_item(input u2a_pkg::cmd_t cmd, input logic [31:0] value,
                           input int idle_pct);
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 60);
    end
    if (gap > 0) begin
      start   <= 1'b0;
      request <= 33'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    request.command <= cmd;
    request.value   <= value;
    do @(posedge clk); while (busy);
  endtask

  // Mix of digit counts: full-width values, shifted-down values of every
  // length, tiny values, and powers of two near digit boundaries.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(1, 31);
      2: v = $urandom_range(0, 20);
      default: v = (32'd1 << $urandom_range(0, 31)) - 32'($urandom_range(0, 1));
    endcase
    return v;
  endfunction

  task automatic run_phase(input int idle_pct);
    for (int i = 0; i < PhaseItems; i++) begin
      send_item(($urandom_range(1) == 1) ? u2a_pkg::CMD_HEX : u2a_pkg::CMD_DEC,
                pick_value(), idle_pct);
    end
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero in both radixes, digit-count boundaries, full scale.
    send_item(u2a_pkg::CMD_DEC, 32'd0, 0);
    send_item(u2a_pkg::CMD_HEX, 32'd0, 0);
    send_item(u2a_pkg::CMD_DEC, 32'd1, 0);
    send_item(u2a_pkg::CMD_HEX, 32'd1, 0);
    send_item(u2a_pkg::CMD_DEC, 32'd9, 0);
    send_item(u2a_pkg::CMD_DEC, 32'd10, 0);
    send_item(u2a_pkg::CMD_DEC, 32'd99, 0);
    send_item(u2a_pkg::CMD_DEC, 32'd100, 0);
    send_item(u2a_pkg::CMD_DEC, 32'd999999999, 0);
    send_item(u2a_pkg::CMD_DEC, 32'd1000000000, 0);
    send_item(u2a_pkg::CMD_DEC, 32'hFFFF_FFFF, 0);
    send_item(u2a_pkg::CMD_DEC, 32'h8000_0000, 0);
    send_item(u2a_pkg::CMD_HEX, 32'hF, 0);
    send_item(u2a_pkg::CMD_HEX, 32'h10, 0);
    send_item(u2a_pkg::CMD_HEX, 32'h0FFF_FFFF, 0);
    send_item(u2a_pkg::CMD_HEX, 32'h1000_0000, 0);
    send_item(u2a_pkg::CMD_HEX, 32'hFFFF_FFFF, 0);
    send_item(u2a_pkg::CMD_HEX, 32'hABCD_EF01, 0);
    send_item(u2a_pkg::CMD_HEX, 32'h1234_5678, 0);
    send_item(u2a_pkg::CMD_HEX, 32'h8000_0000, 0);
    send_item(u2a_pkg::CMD_DEC, 32'd4294967286, 0);

    // Random phases: back to back, sender idle about half the time, back to
    // back again (the receiver has no stall to exercise), then light idling.
    run_phase(0);
    run_phase(52);
    run_phase(0);
    run_phase(28);
    start <= 1'b0;

    // Drain: wait for every predicted digit, then let the block settle.
    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (board.errors == 0) begin
      $display("unsigned_to_ascii_digits test passed");
    end else begin
      $display("unsigned_to_ascii_digits test failed");
    end
    $finish;
  end
endmodule
